### src/icftm_pkg.sv
// Shared types and constants for the instruction-fetch timing model.
package icftm_pkg;

  localparam int NumWays  = 8;
  localparam int NumSets  = 64;
  localparam int WayW     = 3;
  localparam int SetW     = 6;
  localparam int TagW     = 21;
  localparam int WordW    = 3;
  localparam int CntW     = 4;
  localparam int DelayW   = 12;
  localparam int CfgW     = 8;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgInternal = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHit      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMissInit = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPerWord  = 2'd3;

  localparam logic [CntW-1:0] FullCount = 4'd7;

  typedef struct packed {
    logic [31:0] fetch_address;
    logic        in_internal_memory;
  } fetch_req_t;

  typedef struct packed {
    logic [DelayW-1:0] fetch_delay;
    logic              was_miss;
  } fetch_rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture request, issue set read
    logic resolve;  // compute result, update stores
    logic clear;    // clear one set of valid bits
    logic [SetW-1:0] clear_set;
  } dp_cmd_t;

endpackage

### src/icache_fetch_timing_model.sv
// Top level of the instruction-fetch timing model.
//
//  channel | signals                          | transaction
//  fetch   | in_valid_i/in_ready_o/in_data_i  | address and internal flag
//  result  | out_valid_o/out_ready_i/out_data_o | delay and miss flag
//  config  | cfg_we_i/cfg_idx_i/cfg_data_i    | register write, no wait
//
// Each fetch first reads the set row, then resolves and writes back the
// row and the previous line's count.
// After reset a clearing pass sweeps the valid bits of all 64 sets; no fetch
// is taken meanwhile. A stalled result holds; the next fetch is taken as
// soon as the result register will be free.
module icache_fetch_timing_model import icftm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fetch_req_t         in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fetch_rsp_t         out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW:0]   cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  dp_cmd_t             cmd;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic                cfg_in_range;

  // Drop writes to indexes past the last register.
  icftm_cfg_dec u_dec (
    .cfg_we_i (cfg_we_i), .cfg_idx_i(cfg_idx_i), .we_o(cfg_we), .idx_o(cfg_idx)
  );
  icftm_placeholder_unused u_rng (.idx_i(cfg_idx_i), .in_range_o(cfg_in_range));

  icftm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .cmd_o(cmd)
  );

  icftm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(in_data_i),
    .cfg_we_i(cfg_we && cfg_in_range), .cfg_idx_i(cfg_idx), .cfg_data_i,
    .rsp_o(out_data_o)
  );

endmodule

### src/icftm_ctrl.sv
// Controller: clearing pass, then a two-step lookup and update sequence.
module icftm_ctrl import icftm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StLook  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [SetW-1:0] clr_q, clr_d;
  logic            ovld_q, ovld_d;
  logic            accept;

  // A new transaction may enter while the last result waits, as long as the
  // result register will be free when this one resolves.
  assign in_ready_o  = (state_q == StIdle) && (!ovld_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    ovld_d  = ovld_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear     = 1'b1;
        cmd_o.clear_set = clr_q;
        clr_d           = clr_q + 1'b1;
        if (clr_q == SetW'(NumSets - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = StLook;
        end
      end
      StLook: begin
        if (!ovld_d) begin
          cmd_o.resolve = 1'b1;
          ovld_d        = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ovld_q  <= ovld_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.resolve |-> !ovld_q || out_ready_i)
    else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.load |=> state_q == StLook)
    else $error("load did not start lookup");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.resolve |=> ovld_q)
    else $error("resolve lost result");

endmodule

### src/icftm_datapath.sv
// Datapath: tag and count store, last-line record, LFSR, delay arithmetic.
module icftm_datapath import icftm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  fetch_req_t        req_i,
  input  logic              cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  output fetch_rsp_t        rsp_o
);

  // Store rows hold all eight ways of one set; valid bits in a row memory.
  logic [NumWays-1:0][TagW-1:0] tag_mem [NumSets];
  logic [NumWays-1:0][CntW-1:0] cnt_mem [NumSets];
  logic [NumWays-1:0]           vld_mem [NumSets];

  logic [NumWays-1:0][TagW-1:0] tag_rd_q;
  logic [NumWays-1:0][CntW-1:0] cnt_rd_q;
  logic [NumWays-1:0]           vld_rd_q;

  logic [CfgW-1:0] int_dly_q, hit_dly_q, miss_dly_q, pw_dly_q;
  logic            req_int_q;
  logic [TagW-1:0] req_tag_q;
  logic [SetW-1:0] req_set_q;
  logic [WordW-1:0] req_word_q;

  logic            ll_vld_q;
  logic [WayW-1:0] ll_way_q;
  logic [SetW-1:0] ll_set_q;
  logic [CntW-1:0] ll_cnt_q;
  logic [7:0]      lfsr_q, lfsr_nx;
  fetch_rsp_t      rsp_q;

  logic            hit, inv_found;
  logic [WayW-1:0] hit_way, inv_way, way_sel;
  logic [CntW-1:0] cnt_sel;
  logic            grow, ll_charge, ll_same_slot;
  logic [CntW-1:0] words_main, words_wr;
  logic [3:0]      mult_a;
  logic [DelayW-1:0] delay;

  always_comb begin
    hit = 1'b0; hit_way = '0; inv_found = 1'b0; inv_way = '0;
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (vld_rd_q[w] && tag_rd_q[w] == req_tag_q) begin
        hit = 1'b1; hit_way = WayW'(w);
      end
      if (!vld_rd_q[w]) begin
        inv_found = 1'b1; inv_way = WayW'(w);
      end
    end
  end

  assign lfsr_nx = {lfsr_q[6:0], ~(lfsr_q[7] ^ lfsr_q[3] ^ lfsr_q[2] ^ lfsr_q[1])};
  assign way_sel = hit ? hit_way : (inv_found ? inv_way : lfsr_nx[WayW-1:0]);
  assign cnt_sel = cnt_rd_q[hit_way];
  assign grow    = !hit || ({1'b0, req_word_q} > cnt_sel);
  assign ll_same_slot = (ll_way_q == way_sel) && (ll_set_q == req_set_q);
  assign ll_charge = ll_vld_q && (hit ? !ll_same_slot : (ll_cnt_q != FullCount));

  // Word counts charged: the newly streamed words plus the rest of the last line.
  always_comb begin
    mult_a = hit ? 4'({1'b0, req_word_q} - cnt_sel) : {1'b0, req_word_q};
    if (ll_charge) mult_a = mult_a + (FullCount - ll_cnt_q);
  end

  always_comb begin
    if (req_int_q)   delay = DelayW'(int_dly_q);
    else if (!grow)  delay = DelayW'(hit_dly_q);
    else             delay = DelayW'(pw_dly_q) * DelayW'(mult_a)
                             + (hit ? '0 : DelayW'(miss_dly_q));
  end

  assign words_main = (ll_charge && ll_same_slot) ? FullCount : {1'b0, req_word_q};
  assign words_wr   = words_main;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_int_q  <= req_i.in_internal_memory;
      req_tag_q  <= req_i.fetch_address[31:11];
      req_set_q  <= req_i.fetch_address[10:5];
      req_word_q <= req_i.fetch_address[4:2];
      tag_rd_q   <= tag_mem[req_i.fetch_address[10:5]];
      cnt_rd_q   <= cnt_mem[req_i.fetch_address[10:5]];
      vld_rd_q   <= vld_mem[req_i.fetch_address[10:5]];
    end
    if (cmd_i.clear) vld_mem[cmd_i.clear_set] <= '0;
    if (cmd_i.resolve && !req_int_q && grow) begin
      tag_mem[req_set_q][way_sel] <= req_tag_q;
      vld_mem[req_set_q][way_sel] <= 1'b1;
      cnt_mem[req_set_q][way_sel] <= words_wr;
      if (ll_charge && !ll_same_slot) cnt_mem[ll_set_q][ll_way_q] <= FullCount;
    end
    if (cmd_i.resolve) rsp_q <= '{fetch_delay: delay, was_miss: !req_int_q && !hit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_dly_q <= 8'd1; hit_dly_q <= 8'd1; miss_dly_q <= 8'd10; pw_dly_q <= 8'd2;
      ll_vld_q <= 1'b0; ll_way_q <= '0; ll_set_q <= '0; ll_cnt_q <= '0;
      lfsr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgInternal: int_dly_q  <= cfg_data_i;
          CfgHit:      hit_dly_q  <= cfg_data_i;
          CfgMissInit: miss_dly_q <= cfg_data_i;
          CfgPerWord:  pw_dly_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.resolve && !req_int_q && grow) begin
        ll_vld_q <= 1'b1; ll_way_q <= way_sel; ll_set_q <= req_set_q;
        ll_cnt_q <= {1'b0, req_word_q};
        if (!hit && !inv_found) lfsr_q <= lfsr_nx;
      end
    end
  end

  assign rsp_o = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.resolve && !req_int_q && !hit |=> ll_vld_q)
    else $error("miss left no last line");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_i.load && cmd_i.resolve))
    else $error("load and resolve together");

endmodule

### src/icftm_cfg_dec.sv
// Configuration write decoder: filters writes beyond the register list.
module icftm_cfg_dec import icftm_pkg::*; (
  input  logic               cfg_we_i,
  input  logic [CfgIdxW:0]   cfg_idx_i,
  output logic               we_o,
  output logic [CfgIdxW-1:0] idx_o
);
  assign we_o  = cfg_we_i && !cfg_idx_i[CfgIdxW];
  assign idx_o = cfg_idx_i[CfgIdxW-1:0];
endmodule

### src/icftm_placeholder_unused.sv
// Configuration index range helper.
module icftm_placeholder_unused import icftm_pkg::*; (
  input  logic [CfgIdxW:0] idx_i,
  output logic             in_range_o
);
  assign in_range_o = (idx_i <= (CfgIdxW+1)'(CfgPerWord));
endmodule
